// ===== src/prq_pkg.sv =====
// Shared types and constants for the ready / I/O process queues.
// Holds field widths, command and status codes, and the word structs.
// No dependencies.
`default_nettype none

package prq_pkg;

    // Field widths of the command and result words
    localparam int FUNC_W = 3;
    localparam int PID_W  = 16;
    localparam int IDX_W  = 4;
    localparam int STAT_W = 3;
    localparam int CNT_W  = 5;

    // Default sizing
    localparam int DEF_MAX_PROCS = 16;
    localparam int DEF_ID_WIDTH  = 16;

    // Command codes
    typedef logic [FUNC_W-1:0] t_func;
    localparam t_func FN_CREATE   = 3'd0;
    localparam t_func FN_REQ_IO   = 3'd1;
    localparam t_func FN_DONE_IO  = 3'd2;
    localparam t_func FN_KILL     = 3'd3;
    localparam t_func FN_RD_READY = 3'd4;
    localparam t_func FN_RD_IO    = 3'd5;

    // Status codes
    typedef logic [STAT_W-1:0] t_status;
    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_NOT_FOUND = 3'd1;
    localparam t_status ST_NOT_READY = 3'd2;
    localparam t_status ST_NOT_IO    = 3'd3;
    localparam t_status ST_FULL      = 3'd4;
    localparam t_status ST_EXHAUSTED = 3'd5;
    localparam t_status ST_BAD_INDEX = 3'd6;

    // Command word
    typedef struct packed {
        t_func             func;
        logic [PID_W-1:0]  pid;
        logic [IDX_W-1:0]  index;
    } t_cmd;

    // Result word
    typedef struct packed {
        t_status           status;
        logic [PID_W-1:0]  result_pid;
        logic [CNT_W-1:0]  ready_count;
        logic [CNT_W-1:0]  io_count;
    } t_result;

    // Per-queue control from the sequencer to the cell row
    typedef struct packed {
        logic cap;      // capture match flags against the key
        logic remove;   // close the gap at the matched entry
        logic push;     // append at the tail
    } t_q_ctrl;

endpackage

`default_nettype wire

// ===== src/prq_cell.sv =====
// One queue entry: holds an id, registers its match flag, shifts from its neighbor.
// Depends on prq_pkg.
`default_nettype none

module prq_cell #(
    parameter int ID_WIDTH = prq_pkg::DEF_ID_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire prq_pkg::t_q_ctrl         i_ctrl,
    input  wire logic [prq_pkg::PID_W-1:0] i_key,
    input  wire logic                     i_live,
    input  wire logic                     i_wr_sel,
    input  wire logic [ID_WIDTH-1:0]      i_wr_id,
    input  wire logic [ID_WIDTH-1:0]      i_nbr_id,
    input  wire logic                     i_gap,
    output logic      [ID_WIDTH-1:0]      o_id,
    output logic                          o_hit,
    output logic                          o_gap
);
    import prq_pkg::*;

    localparam int CMP_W = (ID_WIDTH > PID_W) ? ID_WIDTH : PID_W;

    logic [ID_WIDTH-1:0] r_id;
    logic                r_hit;

    // Gap starts at the matched entry and runs toward the tail
    assign o_gap = i_gap | r_hit;
    assign o_id  = r_id;
    assign o_hit = r_hit;

    // Capture match, then append or shift down
    always_ff @(posedge i_clk) begin
        if (i_ctrl.cap) begin
            r_hit <= i_live && (CMP_W'(r_id) == CMP_W'(i_key));
        end
        if (i_ctrl.push && i_wr_sel) begin
            r_id <= i_wr_id;
        end else if (i_ctrl.remove && o_gap) begin
            r_id <= i_nbr_id;
        end
    end

endmodule

`default_nettype wire

// ===== src/prq_queue.sv =====
// One ordered id queue built as a row of prq_cell entries plus a length register.
// Depends on prq_pkg and prq_cell.
`default_nettype none

module prq_queue #(
    parameter int MAX_PROCS = prq_pkg::DEF_MAX_PROCS,
    parameter int ID_WIDTH  = prq_pkg::DEF_ID_WIDTH,
    parameter int LEN_W     = $clog2(MAX_PROCS + 1)
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire prq_pkg::t_q_ctrl          i_ctrl,
    input  wire logic [prq_pkg::PID_W-1:0] i_key,
    input  wire logic [ID_WIDTH-1:0]       i_wr_id,
    input  wire logic [prq_pkg::IDX_W-1:0] i_index,
    output logic                           o_found,
    output logic                           o_idx_ok,
    output logic      [LEN_W-1:0]          o_len,
    output logic      [ID_WIDTH-1:0]       o_rd_id
);
    import prq_pkg::*;

    localparam int RD_N = (MAX_PROCS < 2**IDX_W) ? MAX_PROCS : 2**IDX_W;
    localparam int IW   = (LEN_W > IDX_W) ? LEN_W : IDX_W;

    logic [LEN_W-1:0]    r_len;
    logic [ID_WIDTH-1:0] ids  [MAX_PROCS];
    logic [MAX_PROCS-1:0] hits;
    logic [MAX_PROCS:0]  gaps;

    assign gaps[0] = 1'b0;

    // Row of cells, each shifting from the next one toward the head
    for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
        logic [ID_WIDTH-1:0] nbr;
        if (i == MAX_PROCS - 1) begin : g_last
            assign nbr = ids[i];
        end else begin : g_mid
            assign nbr = ids[i+1];
        end
        prq_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (i_ctrl),
            .i_key    (i_key),
            .i_live   (LEN_W'(i) < r_len),
            .i_wr_sel (LEN_W'(i) == r_len),
            .i_wr_id  (i_wr_id),
            .i_nbr_id (nbr),
            .i_gap    (gaps[i]),
            .o_id     (ids[i]),
            .o_hit    (hits[i]),
            .o_gap    (gaps[i+1])
        );
    end

    assign o_found  = |hits;
    assign o_len    = r_len;
    assign o_idx_ok = IW'(i_index) < IW'(r_len);

    // Select the entry at the read position
    always_comb begin
        o_rd_id = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (i_index == IDX_W'(i)) begin
                o_rd_id = ids[i];
            end
        end
    end

    // Track the length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else if (i_ctrl.remove) begin
            r_len <= r_len - LEN_W'(1);
        end else if (i_ctrl.push && (r_len < LEN_W'(MAX_PROCS))) begin
            r_len <= r_len + LEN_W'(1);
        end
    end

endmodule

`default_nettype wire

// ===== src/process_ready_io_queues.sv =====
// Ready / I/O process queues, top level: command sequencer and two cell-row queues.
// Depends on prq_pkg and prq_queue.
//
// Each command is accepted in the idle state and run in the busy state. At the edge
// that accepts it (start high, busy low) each queue cell compares its id with the
// command's pid and registers a match flag; busy is high for the following cycle,
// at whose end the matched entry is removed by shifting the cells behind it one
// place toward the head and the tail push is written. The result word is on
// o_result for exactly the next cycle with o_result_valid high; the receiver cannot
// stall it, and a new command may be accepted in that same cycle, but none while
// busy. ready_count and io_count give the queue lengths after the command. Reset
// is synchronous and active low; queue entries are not cleared, only the lengths,
// the id counter, the state and the result strobe.
`default_nettype none

module process_ready_io_queues #(
    parameter int MAX_PROCS = prq_pkg::DEF_MAX_PROCS,
    parameter int ID_WIDTH  = prq_pkg::DEF_ID_WIDTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire prq_pkg::t_cmd    i_cmd,
    output logic                  o_result_valid,
    output prq_pkg::t_result      o_result
);
    import prq_pkg::*;

    localparam int LEN_W = $clog2(MAX_PROCS + 1);
    localparam int SUM_W = LEN_W + 1;

    typedef enum logic {S_IDLE, S_EXEC} t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [ID_WIDTH-1:0] r_next_id;
    logic                r_done;
    t_status             r_status;
    logic [PID_W-1:0]    r_rpid;

    logic [ID_WIDTH-1:0] n_next_id;
    t_status             n_status;
    logic [PID_W-1:0]    n_rpid;

    t_q_ctrl             rq_ctrl, io_ctrl;
    logic [ID_WIDTH-1:0] rq_wr_id;
    logic                rq_found, io_found, rq_idx_ok, io_idx_ok;
    logic [LEN_W-1:0]    rq_len, io_len;
    logic [ID_WIDTH-1:0] rq_rd_id, io_rd_id;
    logic                accept, full;

    assign busy   = (r_state == S_EXEC);
    assign accept = start && !busy;
    assign full   = (SUM_W'(rq_len) + SUM_W'(io_len)) >= SUM_W'(MAX_PROCS);

    // Decode the held command and steer both queues
    always_comb begin
        rq_ctrl     = '0;
        io_ctrl     = '0;
        rq_ctrl.cap = accept;
        io_ctrl.cap = accept;
        rq_wr_id    = ID_WIDTH'(r_cmd.pid);
        n_next_id   = r_next_id;
        n_status    = ST_OK;
        n_rpid      = '0;
        if (busy) begin
            unique case (r_cmd.func)
                FN_CREATE: begin
                    if (full) begin
                        n_status = ST_FULL;
                    end else if (r_next_id == '0) begin
                        n_status = ST_EXHAUSTED;
                    end else begin
                        rq_ctrl.push = 1'b1;
                        rq_wr_id     = r_next_id;
                        n_rpid       = PID_W'(r_next_id);
                        n_next_id    = (r_next_id == '1) ? '0 : r_next_id + ID_WIDTH'(1);
                    end
                end
                FN_REQ_IO: begin
                    if (rq_found) begin
                        rq_ctrl.remove = 1'b1;
                        io_ctrl.push   = 1'b1;
                    end else if (io_found) begin
                        n_status = ST_NOT_READY;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                FN_DONE_IO: begin
                    if (io_found) begin
                        io_ctrl.remove = 1'b1;
                        rq_ctrl.push   = 1'b1;
                    end else begin
                        n_status = ST_NOT_IO;
                    end
                end
                FN_KILL: begin
                    if (rq_found) begin
                        rq_ctrl.remove = 1'b1;
                    end else if (io_found) begin
                        io_ctrl.remove = 1'b1;
                    end else begin
                        n_status = ST_NOT_FOUND;
                    end
                end
                FN_RD_READY: begin
                    if (rq_idx_ok) begin
                        n_rpid = PID_W'(rq_rd_id);
                    end else begin
                        n_status = ST_BAD_INDEX;
                    end
                end
                FN_RD_IO: begin
                    if (io_idx_ok) begin
                        n_rpid = PID_W'(io_rd_id);
                    end else begin
                        n_status = ST_BAD_INDEX;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    // Hold state, id counter and the result word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_next_id <= ID_WIDTH'(1);
        end else begin
            r_done    <= busy;
            r_next_id <= n_next_id;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
        if (accept) begin
            r_cmd <= i_cmd;
        end
        if (busy) begin
            r_status <= n_status;
            r_rpid   <= n_rpid;
        end
    end

    prq_queue #(
        .MAX_PROCS (MAX_PROCS),
        .ID_WIDTH  (ID_WIDTH),
        .LEN_W     (LEN_W)
    ) u_ready (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (rq_ctrl),
        .i_key    (i_cmd.pid),
        .i_wr_id  (rq_wr_id),
        .i_index  (r_cmd.index),
        .o_found  (rq_found),
        .o_idx_ok (rq_idx_ok),
        .o_len    (rq_len),
        .o_rd_id  (rq_rd_id)
    );

    prq_queue #(
        .MAX_PROCS (MAX_PROCS),
        .ID_WIDTH  (ID_WIDTH),
        .LEN_W     (LEN_W)
    ) u_io (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (io_ctrl),
        .i_key    (i_cmd.pid),
        .i_wr_id  (ID_WIDTH'(r_cmd.pid)),
        .i_index  (r_cmd.index),
        .o_found  (io_found),
        .o_idx_ok (io_idx_ok),
        .o_len    (io_len),
        .o_rd_id  (io_rd_id)
    );

    // Drive the result word; lengths are already updated in the strobe cycle
    assign o_result_valid         = r_done;
    assign o_result.status        = r_status;
    assign o_result.result_pid    = r_rpid;
    assign o_result.ready_count   = CNT_W'(rq_len);
    assign o_result.io_count      = CNT_W'(io_len);

endmodule

`default_nettype wire

// ===== src/prq_checker.sv =====
// Port-level checks on the ready / I/O process queues, bound to the top level.
// Depends on prq_pkg.
`default_nettype none

module prq_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire prq_pkg::t_cmd    i_cmd,
    input wire logic             o_result_valid,
    input wire prq_pkg::t_result o_result
);
    import prq_pkg::*;

    // An accepted command blocks the port for one cycle with no result shown
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_result_valid)
        else $error("accepted command did not raise busy");

    // Each busy cycle ends and is followed by exactly one result word
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> !busy && o_result_valid)
        else $error("busy cycle not followed by a result");

    // Failed commands return no id
    a_err_no_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_result.status == ST_NOT_FOUND ||
        o_result.status == ST_NOT_READY || o_result.status == ST_NOT_IO ||
        o_result.status == ST_FULL || o_result.status == ST_EXHAUSTED ||
        o_result.status == ST_BAD_INDEX) |-> o_result.result_pid == '0)
        else $error("error result carries an id");

    // Reset leaves the block idle with no result pending
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_result_valid)
        else $error("block not idle after reset");

endmodule

bind process_ready_io_queues prq_checker u_prq_checker (.*);

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for process_ready_io_queues: drives command words, checks result words.
// Depends on prq_pkg and process_ready_io_queues; carries its own model of both queues.
`timescale 1ns / 1ps

module tb;
    import prq_pkg::*;

    localparam int          HALF_PERIOD = 6;
    localparam int          RESET_CYCLES = 10;
    localparam int          MAX_LIVE = DEF_MAX_PROCS;
    localparam int          RANDOM_WORDS = 1820;
    localparam int          BLOCK_WORDS = 100;
    localparam int          MAX_REPORTS = 40;
    localparam int unsigned CYCLE_LIMIT = 1_200_000;
    localparam int          LAST_ID = (1 << PID_W) - 1;

    // Codes the block leaves unused
    localparam t_func FN_SPARE_6 = 3'd6;
    localparam t_func FN_SPARE_7 = 3'd7;

    typedef logic [PID_W-1:0] t_pid;

    // One queued command word and the idle cycles that follow its acceptance
    typedef struct packed {
        logic [3:0] gap;
        t_cmd       cmd;
    } t_cmd_slot;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_cmd    i_cmd = '0;
    logic    busy;
    logic    o_result_valid;
    t_result o_result;

    // Model state: id counter and both queues, head at index 0
    t_pid        next_pid;
    t_pid        ready_ids[$];
    t_pid        io_ids[$];

    t_cmd_slot   cmd_backlog[$];
    t_result     pending_results[$];
    t_cmd_slot   slot;
    int          idle_left;
    int unsigned err_count;
    int unsigned accepted_cnt;
    int unsigned checked_cnt;
    int unsigned cycle_count;
    int unsigned status_hits[8];

    process_ready_io_queues u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Position of an id in a queue, -1 when absent
    function automatic int find_id(input t_pid q[$], input t_pid id);
        for (int i = 0; i < q.size(); i++) begin
            if (q[i] == id) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Advance the model by one command word and return the word it must produce
    function automatic t_result apply_command(input t_cmd c);
        t_result r;
        int      pr;
        int      pi;
        r.status     = ST_OK;
        r.result_pid = '0;
        pr = find_id(ready_ids, c.pid);
        pi = find_id(io_ids, c.pid);
        case (c.func)
            FN_CREATE: begin
                if (ready_ids.size() + io_ids.size() >= MAX_LIVE) begin
                    r.status = ST_FULL;
                end else if (next_pid == '0) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    r.result_pid = next_pid;
                    ready_ids = {ready_ids, next_pid};
                    // the last id wraps the counter to zero, which marks exhaustion
                    next_pid = next_pid + t_pid'(1);
                end
            end
            FN_REQ_IO: begin
                if (pr >= 0) begin
                    ready_ids.delete(pr);
                    io_ids = {io_ids, c.pid};
                end else if (pi >= 0) begin
                    r.status = ST_NOT_READY;
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            FN_DONE_IO: begin
                if (pi >= 0) begin
                    io_ids.delete(pi);
                    ready_ids = {ready_ids, c.pid};
                end else begin
                    r.status = ST_NOT_IO;
                end
            end
            FN_KILL: begin
                if (pr >= 0) begin
                    ready_ids.delete(pr);
                end else if (pi >= 0) begin
                    io_ids.delete(pi);
                end else begin
                    r.status = ST_NOT_FOUND;
                end
            end
            FN_RD_READY: begin
                if (c.index < ready_ids.size()) begin
                    r.result_pid = ready_ids[c.index];
                end else begin
                    r.status = ST_BAD_INDEX;
                end
            end
            FN_RD_IO: begin
                if (c.index < io_ids.size()) begin
                    r.result_pid = io_ids[c.index];
                end else begin
                    r.status = ST_BAD_INDEX;
                end
            end
            default: begin
            end
        endcase
        r.ready_count = CNT_W'(ready_ids.size());
        r.io_count    = CNT_W'(io_ids.size());
        status_hits[r.status]++;
        return r;
    endfunction

    // Driver: hold a word until accepted, idle its gap, then present the next
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cmd <= '0;
            idle_left = 0;
        end else begin
            if (start && !busy) begin
                pending_results = {pending_results, apply_command(i_cmd)};
                accepted_cnt++;
            end
            if (start && busy) begin
                // hold the current word
            end else if (idle_left > 0) begin
                start <= 1'b0;
                idle_left--;
            end else if (cmd_backlog.size() > 0) begin
                slot = cmd_backlog.pop_front();
                i_cmd <= slot.cmd;
                start <= 1'b1;
                idle_left = slot.gap;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic report_field(input string name, input int unsigned exp_v,
                                input int unsigned act_v);
        if (exp_v != act_v) begin
            err_count++;
            if (err_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
            end
        end
    endtask

    // Monitor: compare every result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected result word: expected none, got %0h",
                             $time, o_result);
                end
            end else begin
                report_field("status", pending_results[0].status, o_result.status);
                report_field("result_pid", pending_results[0].result_pid,
                             o_result.result_pid);
                report_field("ready_count", pending_results[0].ready_count,
                             o_result.ready_count);
                report_field("io_count", pending_results[0].io_count, o_result.io_count);
                void'(pending_results.pop_front());
                checked_cnt++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached with %0d words outstanding",
                     $time, pending_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    // Keep the backlog short so picks follow the model closely
    task automatic queue_cmd(input t_func f, input t_pid p, input logic [3:0] idx,
                             input logic [3:0] gap);
        t_cmd_slot s;
        while (cmd_backlog.size() >= 2) begin
            @(posedge i_clk);
        end
        s.gap       = gap;
        s.cmd.func  = f;
        s.cmd.pid   = p;
        s.cmd.index = idx;
        cmd_backlog = {cmd_backlog, s};
    endtask

    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || start || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Mostly a live id from the named queue (0 ready, 1 io, 2 either), else noise
    function automatic t_pid pick_pid(input int src);
        int pick;
        int live;
        pick = $urandom_range(0, 99);
        live = ready_ids.size() + io_ids.size();
        if (pick < 3) begin
            return '0;
        end else if (pick < 15) begin
            return t_pid'($urandom);
        end else if (src == 0 && ready_ids.size() > 0) begin
            return ready_ids[$urandom_range(0, ready_ids.size() - 1)];
        end else if (src == 1 && io_ids.size() > 0) begin
            return io_ids[$urandom_range(0, io_ids.size() - 1)];
        end else if (src == 2 && live > 0) begin
            pick = $urandom_range(0, live - 1);
            return (pick < ready_ids.size()) ? ready_ids[pick]
                                             : io_ids[pick - ready_ids.size()];
        end
        return t_pid'($urandom);
    endfunction

    // Mostly an index within the queue or just past its end
    function automatic logic [3:0] pick_index(input int len);
        if ($urandom_range(0, 3) == 0 || len > 15) begin
            return 4'($urandom);
        end
        return 4'($urandom_range(0, len));
    endfunction

    function automatic logic [3:0] draw_gap(input bit burst);
        return burst ? 4'd0 : 4'($urandom_range(0, 14));
    endfunction

    initial begin
        int    create_wt;
        int    pick;
        bit    burst;
        t_func f;
        t_pid  p;
        t_pid  doomed[$];

        next_pid     = 1;
        err_count    = 0;
        accepted_cnt = 0;
        checked_cnt  = 0;
        cycle_count  = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty reads, fill to full, then each error path
        queue_cmd(FN_RD_READY, '0, 4'd0, draw_gap(0));
        queue_cmd(FN_RD_IO, '0, 4'd15, draw_gap(0));
        repeat (MAX_LIVE) queue_cmd(FN_CREATE, '0, '0, draw_gap($urandom_range(0, 1)));
        queue_cmd(FN_CREATE, 16'hFFFF, 4'hF, draw_gap(0));
        queue_cmd(FN_REQ_IO, 16'd1, '0, draw_gap(1));
        queue_cmd(FN_REQ_IO, 16'd1, '0, draw_gap(0));
        queue_cmd(FN_DONE_IO, 16'd2, '0, draw_gap(1));
        queue_cmd(FN_REQ_IO, 16'd0, '0, draw_gap(0));
        queue_cmd(FN_KILL, 16'hFFFF, '0, draw_gap(1));
        queue_cmd(FN_RD_IO, '0, 4'd0, draw_gap(0));
        queue_cmd(FN_RD_READY, '0, 4'd15, draw_gap(1));
        queue_cmd(FN_RD_READY, '0, 4'd14, draw_gap(0));
        queue_cmd(FN_DONE_IO, 16'd1, '0, draw_gap(1));
        queue_cmd(FN_KILL, 16'd1, '0, draw_gap(0));
        queue_cmd(FN_KILL, 16'd1, '0, draw_gap(1));
        queue_cmd(FN_SPARE_6, 16'h1234, 4'h5, draw_gap(0));
        queue_cmd(FN_SPARE_7, 16'hFFFF, 4'hF, draw_gap(1));

        // Random: blocks that lean toward filling, balancing or draining
        create_wt = 22;
        burst     = 0;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % BLOCK_WORDS == 0) begin
                pick      = $urandom_range(0, 2);
                create_wt = (pick == 0) ? 45 : (pick == 1) ? 22 : 6;
                burst     = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 99) < create_wt) begin
                queue_cmd(FN_CREATE, t_pid'($urandom), 4'($urandom), draw_gap(burst));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 28) begin
                    f = FN_REQ_IO;
                    p = pick_pid(0);
                end else if (pick < 56) begin
                    f = FN_DONE_IO;
                    p = pick_pid(1);
                end else if (pick < 74) begin
                    f = FN_KILL;
                    p = pick_pid(2);
                end else if (pick < 86) begin
                    f = FN_RD_READY;
                    p = t_pid'($urandom);
                end else if (pick < 97) begin
                    f = FN_RD_IO;
                    p = t_pid'($urandom);
                end else begin
                    f = pick[0] ? FN_SPARE_7 : FN_SPARE_6;
                    p = t_pid'($urandom);
                end
                queue_cmd(f, p, pick_index((f == FN_RD_IO) ? io_ids.size()
                                                            : ready_ids.size()),
                          draw_gap(burst));
            end
        end

        // Empty both queues
        wait_drained();
        doomed = ready_ids;
        foreach (io_ids[i]) doomed = {doomed, io_ids[i]};
        foreach (doomed[i]) queue_cmd(FN_KILL, doomed[i], '0, draw_gap(0));
        wait_drained();

        // Short mix on the emptied table, with ids that were never handed out
        queue_cmd(FN_CREATE, '0, '0, draw_gap(0));
        queue_cmd(FN_RD_READY, '0, 4'd15, draw_gap(0));
        queue_cmd(FN_KILL, t_pid'(LAST_ID), '0, draw_gap(0));
        queue_cmd(FN_CREATE, '0, '0, draw_gap(0));
        queue_cmd(FN_CREATE, '0, '0, draw_gap(1));
        queue_cmd(FN_REQ_IO, t_pid'(LAST_ID - 1), '0, draw_gap(0));
        queue_cmd(FN_RD_IO, '0, 4'd0, draw_gap(1));
        queue_cmd(FN_DONE_IO, t_pid'(LAST_ID - 1), '0, draw_gap(0));
        queue_cmd(FN_RD_READY, '0, 4'd14, draw_gap(1));

        // Drain and let the pipeline settle
        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("tb: %0d commands accepted, %0d result words checked, %0d mismatches",
                 accepted_cnt, checked_cnt, err_count);
        $display("tb: ok %0d, not found %0d, not ready %0d, not io %0d, full %0d, %s %0d, %s %0d",
                 status_hits[ST_OK], status_hits[ST_NOT_FOUND], status_hits[ST_NOT_READY],
                 status_hits[ST_NOT_IO], status_hits[ST_FULL], "ids exhausted",
                 status_hits[ST_EXHAUSTED], "bad index", status_hits[ST_BAD_INDEX]);
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
